@@ sv/rfbd_pkg.sv @@
// Shared types, widths, register indexes and helpers for the receptive field box decoder.
package rfbd_pkg;

    localparam int MAP_SIDE  = 1024;

    localparam int POS_W     = 10;
    localparam int SCORE_W   = 16;
    localparam int REGR_W    = 16;
    localparam int CFG16_W   = 16;
    localparam int IMG_W     = 13;
    localparam int OUT_W     = 20;
    localparam int WIDE_W    = 30;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_ORIGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_STRIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_HALF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;

    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd32768;
    localparam logic [CFG16_W-1:0] RST_FIELD_ORIGIN    = 16'd0;
    localparam logic [CFG16_W-1:0] RST_CELL_STRIDE     = 16'd16;
    localparam logic [CFG16_W-1:0] RST_FIELD_HALF      = 16'd16;
    localparam logic [IMG_W-1:0]   RST_IMAGE_WIDTH     = 13'd1280;
    localparam logic [IMG_W-1:0]   RST_IMAGE_HEIGHT    = 13'd720;

    typedef struct packed {
        logic [CFG16_W-1:0] field_origin;
        logic [CFG16_W-1:0] cell_stride;
        logic [CFG16_W-1:0] field_half;
    } rfbd_scale_t;

    typedef struct packed {
        logic signed [REGR_W-1:0] reg_bottom;
        logic signed [REGR_W-1:0] reg_right;
        logic signed [REGR_W-1:0] reg_top;
        logic signed [REGR_W-1:0] reg_left;
        logic [SCORE_W-1:0]       cell_score;
        logic [POS_W-1:0]         cell_row;
        logic [POS_W-1:0]         cell_col;
    } rfbd_cell_t;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 30'sd524287;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -30'sd524288;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/receptive_field_box_decode_unit.sv @@
// Top level: config registers, input beat register, two axis decoders and the result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: feature-map cell, 104 bits
//  m_      | out | m_tvalid/m_tready  | m_tdata: decoded box and score, 96 bits
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata (16 bits)
//
// Beats pass the input register, then the result register; one beat per cycle unless stalled.
// The decode is one pass of logic between the input register and the result register.
// Cells at or below the threshold are dropped in the input register without a result.
// Synchronous active-low reset clears valids and restores the register defaults.
// A stalled result holds; the input register keeps taking beats while it can drain.
module receptive_field_box_decode_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rfbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfbd_pkg::CFG_DW-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_col[9:0] cell_row[19:10] cell_score[35:20] reg_left[51:36]
    // reg_top[67:52] reg_right[83:68] reg_bottom[99:84] zero[103:100]
    input  logic [rfbd_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // box_cx[19:0] box_cy[39:20] box_w[59:40] box_h[79:60] box_score[95:80]
    output logic [rfbd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rfbd_pkg::*;

    logic [SCORE_W-1:0]      thr_reg;
    rfbd_scale_t             scale_reg;
    logic [IMG_W-1:0]        img_w_reg;
    logic [IMG_W-1:0]        img_h_reg;

    logic                    in_vld_reg;
    rfbd_cell_t              cell_reg;
    rfbd_cell_t              cell_next;

    logic                    out_vld_reg;
    logic signed [OUT_W-1:0] cx_reg;
    logic signed [OUT_W-1:0] cy_reg;
    logic signed [OUT_W-1:0] w_reg;
    logic signed [OUT_W-1:0] h_reg;
    logic [SCORE_W-1:0]      score_reg;

    logic signed [OUT_W-1:0] cx_next;
    logic signed [OUT_W-1:0] cy_next;
    logic signed [OUT_W-1:0] w_next;
    logic signed [OUT_W-1:0] h_next;

    logic                    in_map;
    logic                    hit;
    logic                    out_free;
    logic                    in_adv;
    logic                    load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg                <= RST_SCORE_THRESHOLD;
            scale_reg.field_origin <= RST_FIELD_ORIGIN;
            scale_reg.cell_stride  <= RST_CELL_STRIDE;
            scale_reg.field_half   <= RST_FIELD_HALF;
            img_w_reg              <= RST_IMAGE_WIDTH;
            img_h_reg              <= RST_IMAGE_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCORE_THRESHOLD: thr_reg                <= cfg_wdata;
                REG_FIELD_ORIGIN:    scale_reg.field_origin <= cfg_wdata;
                REG_CELL_STRIDE:     scale_reg.cell_stride  <= cfg_wdata;
                REG_FIELD_HALF:      scale_reg.field_half   <= cfg_wdata;
                REG_IMAGE_WIDTH:     img_w_reg              <= cfg_wdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT:    img_h_reg              <= cfg_wdata[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cell_next = rfbd_cell_t'(s_tdata[$bits(rfbd_cell_t)-1:0]);

    assign in_map = (32'(cell_reg.cell_col) < MAP_SIDE) && (32'(cell_reg.cell_row) < MAP_SIDE);
    assign hit    = in_map && (cell_reg.cell_score > thr_reg);

    assign out_free = !out_vld_reg || m_tready;
    assign in_adv   = in_vld_reg && (!hit || out_free);
    assign load_out = in_vld_reg && hit && out_free;
    assign s_tready = !in_vld_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cell_reg <= cell_next;
        end
    end

    rfbd_axis u_axis_x (
        .pos    (cell_reg.cell_col),
        .reg_a  (cell_reg.reg_left),
        .reg_b  (cell_reg.reg_right),
        .scale  (scale_reg),
        .img    (img_w_reg),
        .center (cx_next),
        .size   (w_next)
    );

    rfbd_axis u_axis_y (
        .pos    (cell_reg.cell_row),
        .reg_a  (cell_reg.reg_top),
        .reg_b  (cell_reg.reg_bottom),
        .scale  (scale_reg),
        .img    (img_h_reg),
        .center (cy_next),
        .size   (h_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= load_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            score_reg <= cell_reg.cell_score;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {score_reg, h_reg, w_reg, cy_reg, cx_reg};

`ifndef SYNTHESIS
    a_rise_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(in_vld_reg))
        else $error("result appeared without a held beat");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input stalled while input register empty");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && hit && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input taken while a hit beat is blocked");

    a_score_above: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (score_reg > thr_reg))
        else $error("result score not above threshold");
`endif

endmodule

@@ sv/rfbd_axis.sv @@
// One axis of the box decode: field center, corner offsets, ordering, clamping, size and center.
module rfbd_axis (
    input  logic [rfbd_pkg::POS_W-1:0]          pos,
    input  logic signed [rfbd_pkg::REGR_W-1:0]  reg_a,
    input  logic signed [rfbd_pkg::REGR_W-1:0]  reg_b,
    input  rfbd_pkg::rfbd_scale_t               scale,
    input  logic [rfbd_pkg::IMG_W-1:0]          img,
    output logic signed [rfbd_pkg::OUT_W-1:0]   center,
    output logic signed [rfbd_pkg::OUT_W-1:0]   size
);
    import rfbd_pkg::*;

    logic [25:0]               pos_prod;
    logic [26:0]               fc;
    logic signed [32:0]        prod_a;
    logic signed [32:0]        prod_b;
    logic signed [32:0]        rnd_a;
    logic signed [32:0]        rnd_b;
    logic signed [20:0]        off_a;
    logic signed [20:0]        off_b;
    logic signed [28:0]        corner_a;
    logic signed [28:0]        corner_b;
    logic signed [28:0]        lo;
    logic signed [28:0]        hi;
    logic signed [28:0]        lo_c;
    logic signed [28:0]        hi_c;
    logic signed [18:0]        lim;
    logic signed [WIDE_W-1:0]  sz;
    logic signed [WIDE_W-1:0]  sum;
    logic signed [WIDE_W-1:0]  half_sum;

    assign pos_prod = 26'(scale.cell_stride) * 26'(pos);
    assign fc       = 27'(scale.field_origin) + 27'(pos_prod);

    // Q4.12 times 1/16 pixel, round half up back to 1/16 pixel
    assign prod_a = 33'(reg_a) * 33'($signed({1'b0, scale.field_half}));
    assign prod_b = 33'(reg_b) * 33'($signed({1'b0, scale.field_half}));
    assign rnd_a  = prod_a + 33'sd2048;
    assign rnd_b  = prod_b + 33'sd2048;
    assign off_a  = rnd_a[32:12];
    assign off_b  = rnd_b[32:12];

    assign corner_a = $signed({2'b00, fc}) - 29'(off_a);
    assign corner_b = $signed({2'b00, fc}) - 29'(off_b);

    assign lo = (corner_a < corner_b) ? corner_a : corner_b;
    assign hi = (corner_a < corner_b) ? corner_b : corner_a;

    assign lim  = $signed({2'b00, img, 4'b0000}) - 19'sd16;
    assign lo_c = (lo < 29'sd0) ? 29'sd0 : lo;
    assign hi_c = (hi > 29'(lim)) ? 29'(lim) : hi;

    assign sz       = 30'(hi_c) - 30'(lo_c);
    assign sum      = 30'(hi_c) + 30'(lo_c);
    assign half_sum = sum >>> 1;

    assign size   = sat_out(sz);
    assign center = sat_out(half_sum);

endmodule
